### design/lmb_pkg.sv
`timescale 1ns / 1ps

package lmb_pkg;

	localparam int TICK_W    = 32;
	localparam int LED_W     = 4;
	localparam int REG_CHANS = 4;
	localparam int TIME_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 34;

	localparam logic [TICK_W-1:0] FULL_SCALE = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_ON     = 2'd1;
	localparam logic [1:0] MODE_TOGGLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CH_FIRST   = 3'd1;

	typedef struct packed {
		logic [TIME_W-1:0] off_time;
		logic [TIME_W-1:0] on_time;
		logic [1:0]        mode;
	} setting_t;

	typedef struct packed {
		logic [TICK_W-1:0] prev_tick;
		logic [TICK_W-1:0] elapsed;
	} entry_t;

	typedef struct packed {
		logic vld;
		logic lit;
		logic wr;
	} chan_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} seq_state_t;

endpackage

### design/lmb_ram.sv
`timescale 1ns / 1ps

module lmb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/lmb_chan.sv
`timescale 1ns / 1ps

module lmb_chan import lmb_pkg::*; #(
	parameter int CW = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  logic [CW-1:0]     ch_s1,
	input  entry_t            rd_entry,
	input  logic              rd_entry_vld,
	input  setting_t          setting,
	input  logic [TICK_W-1:0] now_tick,
	input  logic [TICK_W-1:0] tick_limit,
	output chan_stat_t        stat,
	output logic [CW-1:0]     wb_ch,
	output entry_t            wb_entry
);

	logic [TICK_W-1:0] cnt;
	logic [TICK_W-1:0] prev;
	logic [TIME_W:0]   period;
	logic              lit_tog;
	logic [TICK_W-1:0] base;
	logic [TICK_W-1:0] delta;
	logic              toggle;

	logic              vld_s2;
	logic [CW-1:0]     ch_s2;
	logic              lit_s2;
	logic              toggle_s2;
	logic [TICK_W-1:0] base_s2;
	logic [TICK_W-1:0] delta_s2;
	logic [TICK_W:0]   sum;

	always_comb begin
		cnt    = rd_entry_vld ? rd_entry.elapsed : '0;
		prev   = rd_entry_vld ? rd_entry.prev_tick : '0;
		period = {1'b0, setting.on_time} + {1'b0, setting.off_time};
		toggle = (setting.mode == MODE_TOGGLE);
		if (cnt < TICK_W'(setting.on_time)) begin
			lit_tog = 1'b1;
			base    = cnt;
		end else if (cnt < TICK_W'(period)) begin
			lit_tog = 1'b0;
			base    = cnt;
		end else begin
			lit_tog = 1'b1;
			base    = '0;
		end
		if (now_tick >= prev) begin
			delta = now_tick - prev;
		end else begin
			delta = tick_limit - prev + now_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ch_s2     <= ch_s1;
			toggle_s2 <= toggle;
			lit_s2    <= toggle ? lit_tog : (setting.mode == MODE_ON);
			base_s2   <= base;
			delta_s2  <= delta;
		end
	end

	assign sum = {1'b0, base_s2} + {1'b0, delta_s2};

	assign stat.vld           = vld_s2;
	assign stat.lit           = vld_s2 && lit_s2;
	assign stat.wr            = vld_s2 && toggle_s2;
	assign wb_ch              = ch_s2;
	assign wb_entry.prev_tick = now_tick;
	assign wb_entry.elapsed   = sum[TICK_W] ? FULL_SCALE : sum[TICK_W-1:0];

endmodule

### design/multi_channel_led_blinker.sv
`timescale 1ns / 1ps
// Channel   Ports                         Contents
// input     s_tvalid s_tready s_tdata     now_tick, one service pass
// output    m_tvalid m_tready m_tdata     led_states
// config    cfg_we cfg_index cfg_data     tick_limit, channel settings
//
// A pass reads the state memory once a cycle for each of min(CHANNELS, 4)
// channels, then two stages of update and write-back, and the load of the output
// register; the input opens again in the same cycle as the result appears.
// Reset clears the settings, the per-channel entry valid bits and the output valid.
// A finished pass holds, and the input stays closed, until the previous result
// has been taken from the output register.

module multi_channel_led_blinker import lmb_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // [31:0] now_tick
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [3:0] led_states, [7:4] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int ACTIVE = (CHANNELS < REG_CHANS) ? CHANNELS : REG_CHANS;
	localparam int CW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic              rd_en;
	logic              load_out;
	logic              busy;
	logic [CW-1:0]     rd_ch_q;
	logic              vld_s1;
	logic [CW-1:0]     ch_s1;
	logic [TICK_W-1:0] now_q;
	logic [TICK_W-1:0] tick_limit_q;
	setting_t          setting_q [ACTIVE];
	logic [ACTIVE-1:0] entry_vld_q;
	logic [LED_W-1:0]  leds_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	entry_t            rd_entry;
	chan_stat_t        stat;
	logic [CW-1:0]     wb_ch;
	entry_t            wb_entry;

	assign busy = vld_s1 || stat.vld;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_ch_q == CW'(ACTIVE - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy && (!m_tvalid_q || m_tready)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_READ:  rd_en = 1'b1;
			ST_DRAIN: load_out = !busy && (!m_tvalid_q || m_tready);
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_ch_q      <= '0;
			vld_s1       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			tick_limit_q <= FULL_SCALE;
			entry_vld_q  <= '0;
			for (int k = 0; k < ACTIVE; k++) begin
				setting_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (s_tvalid && s_tready) begin
				rd_ch_q <= '0;
			end else if (rd_en) begin
				rd_ch_q <= rd_ch_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we && cfg_index == REG_TICK_LIMIT) begin
				tick_limit_q <= cfg_data[TICK_W-1:0];
			end
			for (int k = 0; k < ACTIVE; k++) begin
				if (cfg_we && cfg_index == REG_CH_FIRST + CFG_IDX_W'(k)) begin
					setting_q[k]   <= cfg_data;
					entry_vld_q[k] <= 1'b0;
				end else if (stat.wr && wb_ch == CW'(k)) begin
					entry_vld_q[k] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q  <= s_tdata[TICK_W-1:0];
			leds_q <= '0;
		end else begin
			for (int k = 0; k < ACTIVE; k++) begin
				if (stat.lit && wb_ch == CW'(k)) begin
					leds_q[k] <= 1'b1;
				end
			end
		end
		if (rd_en) begin
			ch_s1 <= rd_ch_q;
		end
		if (load_out) begin
			m_tdata_q <= {{(8 - LED_W){1'b0}}, leds_q};
		end
	end

	lmb_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ACTIVE)
	) u_state_ram (
		.clk  (clk),
		.we   (stat.wr),
		.waddr(wb_ch),
		.wdata(wb_entry),
		.re   (rd_en),
		.raddr(rd_ch_q),
		.rdata(rd_entry)
	);

	lmb_chan #(
		.CW(CW)
	) u_chan (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_s1      (vld_s1),
		.ch_s1       (ch_s1),
		.rd_entry    (rd_entry),
		.rd_entry_vld(entry_vld_q[ch_s1]),
		.setting     (setting_q[ch_s1]),
		.now_tick    (now_q),
		.tick_limit  (tick_limit_q),
		.stat        (stat),
		.wb_ch       (wb_ch),
		.wb_entry    (wb_entry)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_accept_starts_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_READ && rd_ch_q == '0)
		else $error("accepted pass did not start reading channel zero");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !stat.vld)
		else $error("update pipeline busy while sequencer idle");

	a_write_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		stat.wr |-> state_q == ST_READ || state_q == ST_DRAIN)
		else $error("state memory written outside a pass");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ch_s1 <= CW'(ACTIVE - 1))
		else $error("channel index out of range");
`endif

endmodule
